// ----- design/npn_pkg.sv -----
// Shared types and constants of the Newell polygon normal unit.
package npn_pkg;

    localparam int NORM_BITS    = 16;
    localparam int QUOT_BITS    = 15;
    localparam int QCNT_BITS    = 4;
    localparam int MIN_VERTICES = 3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEGEN    = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_CLOSE,
        S_CLOSE_ACC,
        S_CHECK,
        S_SQ,
        S_RT_LOAD,
        S_RT,
        S_DV_LOAD,
        S_DV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic acc;
        logic close;
        logic sq_init;
        logic sq_step;
        logic rt_init;
        logic rt_step;
        logic dv_init;
        logic dv_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic too_long;
        logic few;
        logic zero;
        logic sq_done;
        logic rt_done;
        logic dv_done;
        logic out_free;
    } t_sts;

endpackage

// ----- design/npn_if.sv -----
// Handshake channels of the Newell polygon normal unit: vertex input and normal output.
interface npn_vtx_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic                         vertex_last;

    modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_last, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, vertex_last, output ready);
endinterface

interface npn_nrm_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [1:0]  status;

    modport source (output valid, normal_x, normal_y, normal_z, status, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface

// ----- design/npn_ctrl.sv -----
// Sequencing state machine of the Newell polygon normal unit.
module npn_ctrl import npn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_ACC;
            end
            S_ACC: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.too_long || i_sts.few) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE:     n_state = S_CLOSE_ACC;
            S_CLOSE_ACC: n_state = S_CHECK;
            S_CHECK:     n_state = i_sts.zero ? S_DONE : S_SQ;
            S_SQ: begin
                if (i_sts.sq_done) n_state = S_RT_LOAD;
            end
            S_RT_LOAD:   n_state = S_RT;
            S_RT: begin
                if (i_sts.rt_done) n_state = S_DV_LOAD;
            end
            S_DV_LOAD:   n_state = S_DV;
            S_DV: begin
                if (i_sts.dv_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_ACC:       o_cmd.acc = 1'b1;
            S_CLOSE:     o_cmd.close = 1'b1;
            S_CLOSE_ACC: o_cmd.acc = 1'b1;
            S_CHECK:     o_cmd.sq_init = !i_sts.zero;
            S_SQ:        o_cmd.sq_step = 1'b1;
            S_RT_LOAD:   o_cmd.rt_init = 1'b1;
            S_RT:        o_cmd.rt_step = 1'b1;
            S_DV_LOAD:   o_cmd.dv_init = 1'b1;
            S_DV:        o_cmd.dv_step = 1'b1;
            S_DONE:      o_cmd.out_load = i_sts.out_free;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// ----- design/npn_dp.sv -----
// Datapath of the Newell polygon normal unit: edge products, sums, square root and division.
module npn_dp import npn_pkg::*; #(
    parameter int MAX_LOOP_VERTICES = 256,
    parameter int COORD_BITS        = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    input  logic signed [COORD_BITS-1:0] i_vx,
    input  logic signed [COORD_BITS-1:0] i_vy,
    input  logic signed [COORD_BITS-1:0] i_vz,
    input  logic                         i_last,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [NORM_BITS-1:0]  o_nx,
    output logic signed [NORM_BITS-1:0]  o_ny,
    output logic signed [NORM_BITS-1:0]  o_nz,
    output logic [1:0]                   o_status
);

    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 2;
    localparam int SW = PW + $clog2(MAX_LOOP_VERTICES + 1);
    localparam int MW = SW;
    localparam int QW = 2 * MW + 2;
    localparam int RW = QW / 2;
    localparam int NW = MW + QUOT_BITS;
    localparam int CW = $clog2(MAX_LOOP_VERTICES + 2);
    localparam int BW = $clog2(MW);
    localparam int IW = $clog2(RW);

    logic signed [C-1:0]  w_v    [3];
    logic signed [C-1:0]  r_first[3];
    logic signed [C-1:0]  r_prev [3];
    logic signed [C-1:0]  w_b    [3];
    logic signed [PW-1:0] w_prod [3];
    logic signed [PW-1:0] r_prod [3];
    logic signed [SW-1:0] r_sum  [3];
    logic [MW-1:0]        w_mag  [3];
    logic [MW-1:0]        r_m    [3];
    logic                 r_sgn  [3];
    logic signed [NORM_BITS-1:0] r_nrm [3];

    logic          r_pend;
    logic          r_last;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_ci;

    logic [QW-1:0] r_mcand;
    logic [MW-1:0] r_mpl;
    logic [QW-1:0] r_sq;
    logic [BW-1:0] r_bit;

    logic [QW-1:0] r_op;
    logic [QW-1:0] r_res;
    logic [QW-1:0] r_one;
    logic [IW-1:0] r_it;
    logic [QW-1:0] w_try;

    logic [NW-1:0]        r_rem;
    logic [NW-1:0]        r_dvs;
    logic [QUOT_BITS-1:0] r_q;
    logic [QCNT_BITS-1:0] r_k;
    logic                 w_fit;
    logic [QUOT_BITS-1:0] w_qn;
    logic [NW-1:0]        w_num_nxt;
    logic [NW-1:0]        w_num_first;
    logic [NW-1:0]        w_dvs0;

    logic       r_ovalid;
    logic [1:0] w_status;
    logic       w_too_long;
    logic       w_few;
    logic       w_zero;

    assign w_v[0] = i_vx;
    assign w_v[1] = i_vy;
    assign w_v[2] = i_vz;

    // The edge always starts at the previous vertex; it ends at the new one or at the first.
    for (genvar g = 0; g < 3; g++) begin : g_edge
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        logic signed [C:0] w_dif;
        logic signed [C:0] w_add;
        assign w_b[g]    = i_cmd.close ? r_first[g] : w_v[g];
        assign w_dif     = (C+1)'(r_prev[J]) - (C+1)'(w_b[J]);
        assign w_add     = (C+1)'(r_prev[K]) + (C+1)'(w_b[K]);
        assign w_prod[g] = PW'(w_dif) * PW'(w_add);
        assign w_mag[g]  = r_sum[g][SW-1] ? MW'(-r_sum[g]) : MW'(r_sum[g]);
    end

    assign w_too_long = r_cnt > CW'(MAX_LOOP_VERTICES);
    assign w_few      = r_cnt < CW'(MIN_VERTICES);
    assign w_zero     = (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0);

    assign w_try  = r_res + r_one;
    assign w_fit  = r_dvs <= r_rem;
    assign w_qn   = {r_q[QUOT_BITS-2:0], w_fit};
    assign w_dvs0 = NW'(r_res[RW-1:0]) << (QUOT_BITS - 1);
    assign w_num_first = (NW'(w_mag[0]) << QUOT_BITS) - NW'(w_mag[0]);
    assign w_num_nxt   = (NW'(r_m[1]) << QUOT_BITS) - NW'(r_m[1]);

    always_comb begin
        if (w_too_long) begin
            w_status = ST_TOO_LONG;
        end else if (w_few || w_zero) begin
            w_status = ST_DEGEN;
        end else begin
            w_status = ST_OK;
        end
    end

    // Control state of the loop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_cnt < CW'(MAX_LOOP_VERTICES)) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_pend <= (r_cnt != '0);
                end else begin
                    r_cnt  <= CW'(MAX_LOOP_VERTICES + 1);
                    r_pend <= 1'b0;
                end
            end else if (i_cmd.close) begin
                r_pend <= 1'b1;
            end else if (i_cmd.acc) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.acc && r_pend) begin
                for (int i = 0; i < 3; i++) r_sum[i] <= r_sum[i] + SW'(r_prod[i]);
            end
            if (i_cmd.out_load) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
                for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Vertex registers and edge products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_last;
            if (r_cnt < CW'(MAX_LOOP_VERTICES)) begin
                for (int i = 0; i < 3; i++) r_prev[i] <= w_v[i];
                if (r_cnt == '0) begin
                    for (int i = 0; i < 3; i++) r_first[i] <= w_v[i];
                end
            end
        end
        if (i_cmd.load || i_cmd.close) begin
            for (int i = 0; i < 3; i++) r_prod[i] <= w_prod[i];
        end
    end

    // Shift-and-add squaring, one multiplier bit a cycle, then the next component; also division.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init || i_cmd.dv_init) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]   <= w_mag[i];
                r_sgn[i] <= r_sum[i][SW-1];
            end
            r_ci <= '0;
        end
        if (i_cmd.sq_init) begin
            r_mcand <= QW'(w_mag[0]);
            r_mpl   <= w_mag[0];
            r_sq    <= '0;
            r_bit   <= '0;
        end else if (i_cmd.sq_step) begin
            if (r_mpl[0]) r_sq <= r_sq + r_mcand;
            if (r_bit == BW'(MW - 1)) begin
                r_bit   <= '0;
                r_ci    <= r_ci + 1'b1;
                r_mcand <= QW'(r_m[1]);
                r_mpl   <= r_m[1];
                r_m[0]  <= r_m[1];
                r_m[1]  <= r_m[2];
            end else begin
                r_bit   <= r_bit + 1'b1;
                r_mcand <= r_mcand << 1;
                r_mpl   <= r_mpl >> 1;
            end
        end
        if (i_cmd.dv_init) begin
            r_rem <= w_num_first;
            r_dvs <= w_dvs0;
            r_q   <= '0;
            r_k   <= QCNT_BITS'(QUOT_BITS - 1);
        end else if (i_cmd.dv_step) begin
            if (r_k == '0) begin
                r_nrm[2] <= r_sgn[0] ? -NORM_BITS'(w_qn) : NORM_BITS'(w_qn);
                r_nrm[1] <= r_nrm[2];
                r_nrm[0] <= r_nrm[1];
                r_ci     <= r_ci + 1'b1;
                r_m[0]   <= r_m[1];
                r_m[1]   <= r_m[2];
                r_sgn[0] <= r_sgn[1];
                r_sgn[1] <= r_sgn[2];
                r_rem    <= w_num_nxt;
                r_dvs    <= w_dvs0;
                r_q      <= '0;
                r_k      <= QCNT_BITS'(QUOT_BITS - 1);
            end else begin
                if (w_fit) r_rem <= r_rem - r_dvs;
                r_q   <= w_qn;
                r_dvs <= r_dvs >> 1;
                r_k   <= r_k - 1'b1;
            end
        end
    end

    // Digit-by-digit integer square root, one result bit a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rt_init) begin
            r_op  <= r_sq;
            r_res <= '0;
            r_one <= QW'(1) << (QW - 2);
            r_it  <= '0;
        end else if (i_cmd.rt_step) begin
            if (r_op >= w_try) begin
                r_op  <= r_op - w_try;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
            r_it  <= r_it + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status <= w_status;
            o_nx     <= (w_status == ST_OK) ? r_nrm[0] : '0;
            o_ny     <= (w_status == ST_OK) ? r_nrm[1] : '0;
            o_nz     <= (w_status == ST_OK) ? r_nrm[2] : '0;
        end
    end

    assign o_out_valid = r_ovalid;

    always_comb begin
        o_sts          = '0;
        o_sts.last     = r_last;
        o_sts.too_long = w_too_long;
        o_sts.few      = w_few;
        o_sts.zero     = w_zero;
        o_sts.sq_done  = (r_bit == BW'(MW - 1)) && (r_ci == 2'd2);
        o_sts.rt_done  = r_it == IW'(RW - 1);
        o_sts.dv_done  = (r_k == '0) && (r_ci == 2'd2);
        o_sts.out_free = !r_ovalid || i_out_ready;
    end

endmodule

// ----- design/newell_polygon_normal.sv -----
// Top level of the Newell polygon normal unit.
//
// Vertices of one polygon loop enter on i_vtx, one item per vertex, and
// vertex_last marks the final vertex. One result item per loop leaves on
// o_nrm: the unit normal in Q1.15 (32767 as one) and a status code, which is
// ok, degenerate (fewer than three vertices or a zero normal) or too_long
// (more than MAX_LOOP_VERTICES vertices).
// A vertex item is accepted in S_IDLE, which forms and registers its edge
// products, and S_ACC then adds them to the Newell sums. The final vertex of
// a good loop then runs the closing edge, a bit-serial squaring of the three
// sums (SW bits each, SW = 2*COORD_BITS + 2 + clog2(MAX_LOOP_VERTICES + 1)),
// a bit-serial square root and three divisions before the result is loaded.
// Loops that are too short or too long go from S_ACC straight to the result,
// and a zero normal goes there after the closing edge and the S_CHECK state.
// The shift-and-add squarer takes the largest share of a good loop's run.
// Reset clears the loop state and empties the result register, and the block
// is then ready for the first vertex of a loop. A result waits in its register
// while the receiver stalls; the next loop may start meanwhile, and only its
// own result waits for the register to empty.
module newell_polygon_normal import npn_pkg::*; #(
    parameter int MAX_LOOP_VERTICES = 256,
    parameter int COORD_BITS        = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    npn_vtx_if.sink    i_vtx,
    npn_nrm_if.source  o_nrm
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The state machine only steps the datapath; all arithmetic sits below it.
    npn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vtx.valid),
        .o_ready (i_vtx.ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    npn_dp #(
        .MAX_LOOP_VERTICES (MAX_LOOP_VERTICES),
        .COORD_BITS        (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_vx        (i_vtx.vertex_x),
        .i_vy        (i_vtx.vertex_y),
        .i_vz        (i_vtx.vertex_z),
        .i_last      (i_vtx.vertex_last),
        .i_out_ready (o_nrm.ready),
        .o_out_valid (o_nrm.valid),
        .o_nx        (o_nrm.normal_x),
        .o_ny        (o_nrm.normal_y),
        .o_nz        (o_nrm.normal_z),
        .o_status    (o_nrm.status)
    );

endmodule
